// File: hdl/dlf_pkg.sv
// Package for the dense layer forward unit: payload words, register codes,
// cell control and divider status structs, and the sigmoid and exp lookup tables.
// No dependencies.
package dlf_pkg;

  localparam int DATA_W          = 16;
  localparam int IDX_W           = 6;
  localparam int CNT_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int RESULT_LIMIT    = 64;
  localparam int MAX_INPUTS_DEF  = 64;
  localparam int MAX_NEURONS_DEF = 64;
  localparam int TAB_W           = 13;  // table values stay at or below 4096
  localparam int TOTAL_W         = 19;  // sum of up to 64 exp values
  localparam int DIVN_W          = 26;  // e * 4096 + total / 2

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_INPUT  = 1'b1;

  typedef enum logic [1:0] {
    ACT_SIGMOID = 2'd0,
    ACT_RELU    = 2'd1,
    ACT_TANH    = 2'd2,
    ACT_SOFTMAX = 2'd3
  } act_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACT_MODE  = 2'd0,
    REG_IN_COUNT  = 2'd1,
    REG_OUT_COUNT = 2'd2,
    REG_BIAS      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         in_index;
    logic [IDX_W-1:0]         neuron_index;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] activation;
    logic                     out_last;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // sigmoid(k/2) in Q4.12, k = 0..16
  function automatic logic [TAB_W-1:0] sig_tab_f(input logic [4:0] k);
    logic [TAB_W-1:0] r;
    case (k)
      5'd0:    r = 13'd2048;
      5'd1:    r = 13'd2550;
      5'd2:    r = 13'd2994;
      5'd3:    r = 13'd3349;
      5'd4:    r = 13'd3608;
      5'd5:    r = 13'd3785;
      5'd6:    r = 13'd3902;
      5'd7:    r = 13'd3976;
      5'd8:    r = 13'd4022;
      5'd9:    r = 13'd4051;
      5'd10:   r = 13'd4069;
      5'd11:   r = 13'd4079;
      5'd12:   r = 13'd4086;
      5'd13:   r = 13'd4090;
      5'd14:   r = 13'd4092;
      5'd15:   r = 13'd4094;
      default: r = 13'd4095;
    endcase
    return r;
  endfunction

  // exp(-k/2) in Q4.12, k = 0..16
  function automatic logic [TAB_W-1:0] exp_tab_f(input logic [4:0] k);
    logic [TAB_W-1:0] r;
    case (k)
      5'd0:    r = 13'd4096;
      5'd1:    r = 13'd2484;
      5'd2:    r = 13'd1507;
      5'd3:    r = 13'd914;
      5'd4:    r = 13'd554;
      5'd5:    r = 13'd336;
      5'd6:    r = 13'd204;
      5'd7:    r = 13'd124;
      5'd8:    r = 13'd75;
      5'd9:    r = 13'd46;
      5'd10:   r = 13'd28;
      5'd11:   r = 13'd17;
      5'd12:   r = 13'd10;
      5'd13:   r = 13'd6;
      5'd14:   r = 13'd4;
      5'd15:   r = 13'd2;
      default: r = 13'd1;
    endcase
    return r;
  endfunction

  // exp(-d) for d >= 0 in Q4.12, linear interpolation, zero from 8.0 up
  function automatic logic [TAB_W-1:0] exp_neg_f(input logic [16:0] d);
    logic [5:0]       idx;
    logic [10:0]      frac;
    logic [TAB_W-1:0] a;
    logic [TAB_W-1:0] b;
    logic [21:0]      p;
    idx  = d[16:11];
    frac = d[10:0];
    a    = exp_tab_f(idx[4:0]);
    b    = exp_tab_f(idx[4:0] + 5'd1);
    p    = 22'(a - b) * 22'(frac);
    if (idx >= 6'd16) begin
      return '0;
    end
    return a - TAB_W'(p >> 11);
  endfunction

endpackage

// File: hdl/dlf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module dlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/dlf_cell.sv
// One neuron cell: weight bank, multiplier and accumulator. Input elements
// pass to the right neighbor; sums shift left on readout.
// Depends on dlf_pkg and dlf_ram.
module dlf_cell #(
  parameter int IAW   = 6,
  parameter int DEPTH = 64,
  parameter int ACC_W = 39
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dlf_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        wr_en_i,
  input  logic [IAW-1:0]              wr_addr_i,
  input  logic [dlf_pkg::DATA_W-1:0]  wr_data_i,
  input  logic                        v_i,
  input  logic [IAW-1:0]              idx_i,
  input  logic signed [dlf_pkg::DATA_W-1:0] x_i,
  output logic                        v_o,
  output logic [IAW-1:0]              idx_o,
  output logic signed [dlf_pkg::DATA_W-1:0] x_o,
  input  logic signed [ACC_W-1:0]     acc_i,
  output logic signed [ACC_W-1:0]     acc_o
);
  import dlf_pkg::*;

  logic                       v_q;
  logic [IAW-1:0]             idx_q;
  logic signed [DATA_W-1:0]   x_q;
  logic [DATA_W-1:0]          w_raw;
  logic                       pv_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    acc_d;

  // weight bank, read at the index arriving from the left
  dlf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH),
    .AW   (IAW)
  ) u_wbank (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data_i),
    .raddr_i(idx_i),
    .rdata_o(w_raw)
  );

  // register the element valid, aligned with the weight read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      pv_q <= 1'b0;
    end else begin
      v_q  <= v_i;
      pv_q <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_i;
    x_q    <= x_i;
    prod_q <= x_q * $signed(w_raw);
  end

  // clear, shift out, or accumulate
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.shift) begin
      acc_d = acc_i;
    end else if (pv_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign v_o   = v_q;
  assign idx_o = idx_q;
  assign x_o   = x_q;
  assign acc_o = acc_q;

endmodule

// File: hdl/dlf_div.sv
// Restoring divider, one quotient bit per cycle, for the softmax scaling.
// Depends on dlf_pkg.
module dlf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dlf_pkg::DIVN_W-1:0]   num_i,
  input  logic [dlf_pkg::TOTAL_W-1:0]  den_i,
  output dlf_pkg::div_stat_t           stat_o,
  output logic [dlf_pkg::DIVN_W-1:0]   quo_o
);
  import dlf_pkg::*;

  localparam int STEP_W = $clog2(DIVN_W + 1);

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [DIVN_W-1:0]   num_q;
  logic [TOTAL_W-1:0]  den_q;
  logic [TOTAL_W:0]    rem_q;
  logic [TOTAL_W:0]    rem_sh;
  logic                fits;

  assign rem_sh = {rem_q[TOTAL_W-1:0], num_q[DIVN_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  // sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIVN_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift in one numerator bit, subtract when the divisor fits
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_q <= {num_q[DIVN_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = num_q;

endmodule

// File: hdl/dense_layer_forward_unit.sv
// Top level of the dense layer forward unit: stores, cell chain, sequencer
// and activation. Depends on dlf_pkg, dlf_ram, dlf_cell and dlf_div.
//
//   channel   direction  handshake                payload
//   in        in         in_valid_i / in_ready_o  in_data_i  (in_word_t)
//   out       out        out_valid_o / out_ready_i out_data_o (out_word_t)
//   cfg       in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Weight loads and non-last input words leave the sequencer in its idle state.
// A last input word starts the layer: the inputs are fed into the cell chain
// and drain through it, the sums shift out into the sums store, in softmax
// the exp values are summed, then each result is computed and offered
// (through the bit-serial divider in softmax).
// No input word is taken until the last result is in the output register.
// Reset is asynchronous; stores have no reset and need no clearing pass.
module dense_layer_forward_unit #(
  parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
  parameter int MAX_NEURONS = dlf_pkg::MAX_NEURONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dlf_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dlf_pkg::out_word_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dlf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dlf_pkg::*;

  localparam int IAW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NAW      = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int ACC_W    = 2 * DATA_W + IAW + 1;
  localparam int NOUT_LIM = (MAX_NEURONS < RESULT_LIMIT) ? MAX_NEURONS : RESULT_LIMIT;
  localparam int DRAIN    = MAX_NEURONS + 4;
  localparam int WT_W     = $clog2(DRAIN + 128 + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FEED   = 9'b000000010,
    S_SHIFT  = 9'b000000100,
    S_SUMEXP = 9'b000001000,
    S_RD     = 9'b000010000,
    S_CALC   = 9'b000100000,
    S_FIN    = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e                   state_q, state_d;
  act_mode_e                act_mode_q;
  logic [CNT_W-1:0]         in_count_q;
  logic [CNT_W-1:0]         out_count_q;
  logic signed [DATA_W-1:0] bias_q;
  logic [CNT_W-1:0]         nin_q, nout_q;
  logic [CNT_W-1:0]         nin_d, nout_d;
  logic [WT_W-1:0]          wt_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     feed_v_q;
  logic [IAW-1:0]           feed_idx_q;
  logic                     rd_v_q;
  logic                     first_q;

  // ---------------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mode_q  <= ACT_SIGMOID;
      in_count_q  <= CNT_W'(64);
      out_count_q <= CNT_W'(64);
      bias_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ACT_MODE:  act_mode_q  <= act_mode_e'(cfg_data_i[1:0]);
        REG_IN_COUNT:  in_count_q  <= cfg_data_i[CNT_W-1:0];
        REG_OUT_COUNT: out_count_q <= cfg_data_i[CNT_W-1:0];
        REG_BIAS:      bias_q      <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // clamp counts at start
  always_comb begin
    nin_d = in_count_q;
    if (in_count_q == '0) begin
      nin_d = CNT_W'(1);
    end else if (32'(in_count_q) > MAX_INPUTS) begin
      nin_d = CNT_W'(MAX_INPUTS);
    end
    nout_d = out_count_q;
    if (out_count_q == '0) begin
      nout_d = CNT_W'(1);
    end else if (32'(out_count_q) > NOUT_LIM) begin
      nout_d = CNT_W'(NOUT_LIM);
    end
  end

  // ---------------------------------------------------------------------
  // input side
  logic in_acc;
  logic in_ok;
  logic start;
  logic w_we;
  logic [IAW-1:0] in_addr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ok      = 32'(in_data_i.in_index) < MAX_INPUTS;
  assign in_addr    = IAW'(32'(in_data_i.in_index));
  assign w_we       = in_acc && (in_data_i.kind == KIND_WEIGHT) && in_ok &&
                      (32'(in_data_i.neuron_index) < MAX_NEURONS);
  assign start      = in_acc && (in_data_i.kind == KIND_INPUT) && in_data_i.last;

  logic [DATA_W-1:0] in_rdata;

  dlf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_INPUTS),
    .AW   (IAW)
  ) u_in_store (
    .clk_i  (clk_i),
    .we_i   (in_acc && (in_data_i.kind == KIND_INPUT) && in_ok),
    .waddr_i(in_addr),
    .wdata_i(in_data_i.value),
    .raddr_i(IAW'(32'(wt_q))),
    .rdata_o(in_rdata)
  );

  // ---------------------------------------------------------------------
  // cell chain
  cell_ctrl_t cell_ctrl;
  logic                     v_c   [MAX_NEURONS];
  logic [IAW-1:0]           idx_c [MAX_NEURONS];
  logic signed [DATA_W-1:0] x_c   [MAX_NEURONS];
  logic signed [ACC_W-1:0]  acc_c [MAX_NEURONS+1];

  assign cell_ctrl.clear = start;
  assign cell_ctrl.shift = (state_q == S_SHIFT);
  assign v_c[0]          = feed_v_q;
  assign idx_c[0]        = feed_idx_q;
  assign x_c[0]          = $signed(in_rdata);
  assign acc_c[MAX_NEURONS] = '0;

  for (genvar k = 0; k < MAX_NEURONS; k++) begin : g_cell
    logic we_k;
    assign we_k = w_we && (32'(in_data_i.neuron_index) == k);
    if (k < MAX_NEURONS - 1) begin : g_mid
      dlf_cell #(.IAW(IAW), .DEPTH(MAX_INPUTS), .ACC_W(ACC_W)) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (cell_ctrl),
        .wr_en_i  (we_k),
        .wr_addr_i(in_addr),
        .wr_data_i(in_data_i.value),
        .v_i      (v_c[k]),
        .idx_i    (idx_c[k]),
        .x_i      (x_c[k]),
        .v_o      (v_c[k+1]),
        .idx_o    (idx_c[k+1]),
        .x_o      (x_c[k+1]),
        .acc_i    (acc_c[k+1]),
        .acc_o    (acc_c[k])
      );
    end else begin : g_tail
      dlf_cell #(.IAW(IAW), .DEPTH(MAX_INPUTS), .ACC_W(ACC_W)) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (cell_ctrl),
        .wr_en_i  (we_k),
        .wr_addr_i(in_addr),
        .wr_data_i(in_data_i.value),
        .v_i      (v_c[k]),
        .idx_i    (idx_c[k]),
        .x_i      (x_c[k]),
        .v_o      (),
        .idx_o    (),
        .x_o      (),
        .acc_i    (acc_c[k+1]),
        .acc_o    (acc_c[k])
      );
    end
  end

  // ---------------------------------------------------------------------
  // round, add bias, saturate the sum leaving cell 0
  logic signed [ACC_W:0]    rnd;
  logic signed [ACC_W:0]    biased;
  logic signed [DATA_W-1:0] sum_sat;

  always_comb begin
    rnd    = ($signed({acc_c[0][ACC_W-1], acc_c[0]}) + (ACC_W+1)'(2048)) >>> 12;
    biased = rnd + (ACC_W+1)'(bias_q);
    if (biased > (ACC_W+1)'(32767)) begin
      sum_sat = 16'sh7fff;
    end else if (biased < -(ACC_W+1)'(32768)) begin
      sum_sat = -16'sh8000;
    end else begin
      sum_sat = DATA_W'(biased);
    end
  end

  logic [DATA_W-1:0]        sum_raw;
  logic signed [DATA_W-1:0] sum_rd;
  logic signed [DATA_W-1:0] mx_q;

  dlf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_NEURONS),
    .AW   (NAW)
  ) u_sums (
    .clk_i  (clk_i),
    .we_i   (state_q == S_SHIFT),
    .waddr_i(NAW'(32'(cnt_q))),
    .wdata_i(sum_sat),
    .raddr_i(NAW'(32'(cnt_q))),
    .rdata_o(sum_raw)
  );

  assign sum_rd = $signed(sum_raw);

  // exp of the distance to the maximum
  logic [16:0]      mx_gap;
  logic [TAB_W-1:0] e_now;
  logic [TOTAL_W-1:0] total_q;

  assign mx_gap = 17'($signed({mx_q[DATA_W-1], mx_q}) - $signed({sum_rd[DATA_W-1], sum_rd}));
  assign e_now  = exp_neg_f(mx_gap);

  // ---------------------------------------------------------------------
  // activation, two stages
  logic signed [16:0] xs;
  logic [16:0]        mag;
  logic [16:0]        arg;
  logic [5:0]         aidx;
  logic [TAB_W-1:0]   a_base, a_next;
  logic [19:0]        a_prod;

  assign xs     = 17'(sum_rd);
  assign mag    = 17'(xs[16] ? -xs : xs);
  assign arg    = (act_mode_q == ACT_TANH) ? 17'(mag << 1) : mag;
  assign aidx   = arg[16:11];
  assign a_base = sig_tab_f(aidx[4:0]);
  assign a_next = sig_tab_f(aidx[4:0] + 5'd1);
  assign a_prod = 20'(a_next - a_base) * 20'(arg[10:0]);

  logic [19:0]              prod_q;
  logic [TAB_W-1:0]         base_q;
  logic                     big_q;
  logic signed [DATA_W-1:0] x_q;
  logic [TAB_W-1:0]         e_q;
  logic [TAB_W-1:0]         s_val;
  logic signed [DATA_W-1:0] th;
  logic signed [DATA_W-1:0] act_val;
  logic signed [DATA_W-1:0] res_q;

  always_comb begin
    s_val = big_q ? TAB_W'(4095) : base_q + TAB_W'(prod_q >> 11);
    th    = DATA_W'(2 * 32'(s_val)) - 16'sd4096;
    case (act_mode_q)
      ACT_SIGMOID: act_val = x_q[DATA_W-1] ? 16'sd4096 - DATA_W'(s_val) : DATA_W'(s_val);
      ACT_RELU:    act_val = (x_q > 16'sd0) ? x_q : 16'sd0;
      ACT_TANH:    act_val = x_q[DATA_W-1] ? -th : th;
      default:     act_val = '0;
    endcase
  end

  // softmax divider
  div_stat_t         div_stat;
  logic [DIVN_W-1:0] div_quo;
  logic              div_start;

  assign div_start = (state_q == S_FIN) && (act_mode_q == ACT_SOFTMAX);

  dlf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ((DIVN_W'(e_q) << 12) + DIVN_W'(total_q >> 1)),
    .den_i  (total_q),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // ---------------------------------------------------------------------
  // sequencer
  logic out_valid_q;
  out_word_t out_q;
  logic out_free;
  logic out_load;

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == S_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start) state_d = S_FEED;
      S_FEED:   if (wt_q == WT_W'(32'(nin_q) + DRAIN)) state_d = S_SHIFT;
      S_SHIFT:  if (cnt_q == nout_q - CNT_W'(1)) begin
                  state_d = (act_mode_q == ACT_SOFTMAX) ? S_SUMEXP : S_RD;
                end
      S_SUMEXP: if (cnt_q == nout_q && !rd_v_q) state_d = S_RD;
      S_RD:     state_d = S_CALC;
      S_CALC:   state_d = S_FIN;
      S_FIN:    state_d = (act_mode_q == ACT_SOFTMAX) ? S_DIV : S_OUT;
      S_DIV:    if (div_stat.done) state_d = S_OUT;
      S_OUT:    if (out_free) begin
                  state_d = (cnt_q == nout_q - CNT_W'(1)) ? S_IDLE : S_RD;
                end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wt_q        <= '0;
      cnt_q       <= '0;
      feed_v_q    <= 1'b0;
      feed_idx_q  <= '0;
      rd_v_q      <= 1'b0;
      nin_q       <= '0;
      nout_q      <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      feed_v_q   <= (state_q == S_FEED) && (wt_q < WT_W'(nin_q));
      feed_idx_q <= IAW'(wt_q);
      rd_v_q     <= (state_q == S_SUMEXP) && (cnt_q < nout_q);
      // advance counters per phase
      case (state_q)
        S_IDLE: begin
          wt_q    <= '0;
          cnt_q   <= '0;
          first_q <= 1'b1;
          if (start) begin
            nin_q  <= nin_d;
            nout_q <= nout_d;
          end
        end
        S_FEED:   wt_q <= wt_q + WT_W'(1);
        S_SHIFT: begin
          first_q <= 1'b0;
          cnt_q   <= (state_d == S_SHIFT) ? cnt_q + CNT_W'(1) : '0;
        end
        S_SUMEXP: begin
          if (state_d != S_SUMEXP) begin
            cnt_q <= '0;
          end else if (cnt_q < nout_q) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_OUT:    if (out_free) cnt_q <= cnt_q + CNT_W'(1);
        default: ;
      endcase
      // drop the output word once taken, load a new one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // data path registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_SHIFT) begin
      if (first_q || sum_sat > mx_q) begin
        mx_q <= sum_sat;
      end
    end
    if (state_q == S_SHIFT) begin
      total_q <= '0;
    end else if (rd_v_q) begin
      total_q <= total_q + TOTAL_W'(e_now);
    end
    if (state_q == S_CALC) begin
      prod_q <= a_prod;
      base_q <= a_base;
      big_q  <= aidx >= 6'd16;
      x_q    <= sum_rd;
      e_q    <= e_now;
    end
    if (state_q == S_FIN) begin
      res_q <= act_val;
    end else if (state_q == S_DIV && div_stat.done) begin
      res_q <= DATA_W'(div_quo);
    end
    if (out_load) begin
      out_q.out_index  <= IDX_W'(cnt_q);
      out_q.activation <= res_q;
      out_q.out_last   <= (cnt_q == nout_q - CNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cell_ctrl.clear && cell_ctrl.shift)) else $error("cell clear during shift");

  a_feed_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feed_v_q |-> state_q == S_FEED) else $error("feed word outside feed phase");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy) else $error("divider busy while idle");

  a_div_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> act_mode_q == ACT_SOFTMAX) else $error("divide outside softmax");

endmodule

// File: test/dense_layer_forward_unit_test.sv
// Testbench for dense_layer_forward_unit: loads weights and inputs, runs layers
// in all activation modes and checks every neuron result against a local model.
// Depends on dlf_pkg and the dense_layer_forward_unit RTL.
module dense_layer_forward_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dlf_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int ITEM_TARGET = 430;
  localparam int SIG_Q[17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022,
                               4051, 4069, 4079, 4086, 4090, 4092, 4094, 4095};
  localparam int EXP_Q[17] = '{4096, 2484, 1507, 914, 554, 336, 204, 124, 75,
                               46, 28, 17, 10, 6, 4, 2, 1};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  dense_layer_forward_unit uut (.*);

  // words waiting for the driver, and activations expected from the block
  in_word_t  pending_words[$];
  out_word_t expected_acts[$];
  int        words_queued = 0;
  int        words_taken = 0;
  int        results_checked = 0;
  int        layers_run = 0;
  int        fails = 0;
  int        cycles = 0;
  bit        no_gaps = 1'b0;

  // predictor state and register copies
  logic signed [15:0] pred_w [64][64];
  logic signed [15:0] pred_x [64];
  act_mode_e          pred_act = ACT_SIGMOID;
  int                 pred_in_cnt = 64;
  int                 pred_out_cnt = 64;
  logic signed [15:0] pred_bias = '0;

  // which store entries the stimulus has written so far
  bit w_set [64][64];
  bit x_set [64];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int sig_half(input int m);
    int idx;
    int fr;
    idx = m >> 11;
    fr  = m & 2047;
    if (idx >= 16) return SIG_Q[16];
    return SIG_Q[idx] + (((SIG_Q[idx+1] - SIG_Q[idx]) * fr) >> 11);
  endfunction

  function automatic int exp_down(input int d);
    int idx;
    int fr;
    idx = d >> 11;
    fr  = d & 2047;
    if (idx >= 16) return 0;
    return EXP_Q[idx] - (((EXP_Q[idx] - EXP_Q[idx+1]) * fr) >> 11);
  endfunction

  // update stores and, on a last input word, queue one activation per neuron
  task automatic predict_layer(input in_word_t w);
    longint    acc;
    longint    total;
    longint    a;
    int        nin;
    int        nout;
    int        sums [64];
    int        mx;
    int        m;
    int        s;
    out_word_t r;
    if (w.kind == KIND_WEIGHT) begin
      pred_w[w.neuron_index][w.in_index] = w.value;
      return;
    end
    pred_x[w.in_index] = w.value;
    if (!w.last) return;
    nin  = (pred_in_cnt == 0) ? 1 : (pred_in_cnt > 64 ? 64 : pred_in_cnt);
    nout = (pred_out_cnt == 0) ? 1 : (pred_out_cnt > 64 ? 64 : pred_out_cnt);
    for (int n = 0; n < nout; n++) begin
      acc = 0;
      for (int i = 0; i < nin; i++) begin
        acc += longint'(pred_w[n][i]) * longint'(pred_x[i]);
      end
      acc = ((acc + 2048) >>> 12) + longint'(pred_bias);
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      sums[n] = int'(acc);
    end
    mx = sums[0];
    total = 0;
    if (pred_act == ACT_SOFTMAX) begin
      for (int n = 1; n < nout; n++) if (sums[n] > mx) mx = sums[n];
      for (int n = 0; n < nout; n++) total += exp_down(mx - sums[n]);
    end
    for (int n = 0; n < nout; n++) begin
      m = sums[n] < 0 ? -sums[n] : sums[n];
      case (pred_act)
        ACT_SIGMOID: begin
          s = sig_half(m);
          a = sums[n] < 0 ? 4096 - s : s;
        end
        ACT_RELU: a = sums[n] > 0 ? sums[n] : 0;
        ACT_TANH: begin
          s = 2 * sig_half(2 * m) - 4096;
          a = sums[n] < 0 ? -s : s;
        end
        default: a = (longint'(exp_down(mx - sums[n])) * 4096 + total / 2) / total;
      endcase
      r.out_index  = n[IDX_W-1:0];
      r.activation = a[15:0];
      r.out_last   = (n + 1 == nout);
      expected_acts.push_back(r);
    end
    layers_run++;
  endtask

  // reset, then timeout watch
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver: predict on each taken word, offer the next one with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_layer(in_data_i);
        words_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 20)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_acts.size() == 0) begin
        $error("unexpected result word: out_index %0d activation %0d",
               out_data_o.out_index, out_data_o.activation);
        fails++;
      end else begin
        e = expected_acts.pop_front();
        results_checked++;
        if (out_data_o.out_index !== e.out_index) begin
          $error("out_index: expected %0d, got %0d", e.out_index, out_data_o.out_index);
          fails++;
        end
        if (out_data_o.activation !== e.activation) begin
          $error("activation: expected %0d, got %0d", e.activation, out_data_o.activation);
          fails++;
        end
        if (out_data_o.out_last !== e.out_last) begin
          $error("out_last: expected %0d, got %0d", e.out_last, out_data_o.out_last);
          fails++;
        end
      end
    end
    out_ready_i <= no_gaps || $urandom_range(0, 99) >= 20;
  end

  // hold until every word is taken and every result has come, then settle
  task automatic wait_idle();
    while (words_taken != words_queued || expected_acts.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_ACT_MODE:  pred_act = act_mode_e'(data[1:0]);
      REG_IN_COUNT:  pred_in_cnt = int'(data[6:0]);
      REG_OUT_COUNT: pred_out_cnt = int'(data[6:0]);
      default:       pred_bias = data;
    endcase
  endtask

  task automatic set_layer(input act_mode_e act, input int ic, input int oc,
                           input logic [15:0] b);
    wait_idle();
    cfg_write(REG_ACT_MODE, 16'(act));
    cfg_write(REG_IN_COUNT, 16'(ic));
    cfg_write(REG_OUT_COUNT, 16'(oc));
    cfg_write(REG_BIAS, b);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_word_t make_word(input logic kind, input int ii, input int ni,
                                         input logic [15:0] val, input logic last);
    in_word_t w;
    w.kind = kind;
    w.in_index = ii[IDX_W-1:0];
    w.neuron_index = ni[IDX_W-1:0];
    w.value = val;
    w.last = last;
    return w;
  endfunction

  task automatic queue_word(input in_word_t w);
    if (w.kind == KIND_WEIGHT) w_set[w.neuron_index][w.in_index] = 1'b1;
    else x_set[w.in_index] = 1'b1;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // mostly moderate values so activations stay off the rails
  function automatic logic [15:0] rand_value();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8191) - 4096);
  endfunction

  function automatic int rand_count(input bit keep_small);
    int r;
    r = $urandom_range(0, 9);
    if (keep_small) return $urandom_range(0, 2);
    if (r == 0) return 0;
    if (r == 1) return 64;
    if (r == 2) return 127;
    return $urandom_range(1, 8);
  endfunction

  // one layer run: fill whatever is missing, add rewrites and noise, shuffle
  task automatic random_layer();
    in_word_t batch[$];
    in_word_t t;
    int       ic;
    int       oc;
    int       nin;
    int       nout;
    int       j;
    logic     kd;
    ic = rand_count(1'b0);
    oc = rand_count(ic == 64 || ic == 127);
    if (oc == 64 || oc == 127) ic = $urandom_range(0, 2);
    set_layer(act_mode_e'($urandom_range(0, 3)), ic, oc, $urandom_range(0, 3) == 0 ?
              16'($urandom) : 16'($urandom_range(0, 4095) - 2048));
    nin  = (ic == 0) ? 1 : (ic > 64 ? 64 : ic);
    nout = (oc == 0) ? 1 : (oc > 64 ? 64 : oc);
    for (int n = 0; n < nout; n++) begin
      for (int i = 0; i < nin; i++) begin
        if (!w_set[n][i] || $urandom_range(0, 3) == 0)
          batch.push_back(make_word(KIND_WEIGHT, i, n, rand_value(), $urandom_range(0, 1)));
      end
    end
    for (int i = 0; i < nin; i++) begin
      if (!x_set[i] || $urandom_range(0, 2) == 0)
        batch.push_back(make_word(KIND_INPUT, i, $urandom_range(0, 63), rand_value(), 1'b0));
    end
    repeat ($urandom_range(0, 4)) begin
      kd = $urandom_range(0, 1);
      batch.push_back(make_word(kd, $urandom_range(0, 63), $urandom_range(0, 63),
                                16'($urandom), kd == KIND_WEIGHT ? 1'($urandom) : 1'b0));
    end
    for (int k = batch.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = batch[k];
      batch[k] = batch[j];
      batch[j] = t;
    end
    foreach (batch[k]) queue_word(batch[k]);
    queue_word(make_word(KIND_INPUT, $urandom_range(0, nin - 1), $urandom_range(0, 63),
                         rand_value(), 1'b1));
  endtask

  initial begin
    int phase;
    // directed: extreme values and indexes, last on a weight load, each mode
    set_layer(ACT_SIGMOID, 2, 2, 16'sd0);
    queue_word(make_word(KIND_WEIGHT, 0, 0, 16'h7fff, 1'b0));
    queue_word(make_word(KIND_WEIGHT, 1, 0, 16'h8000, 1'b0));
    queue_word(make_word(KIND_WEIGHT, 0, 1, 16'h8000, 1'b0));
    queue_word(make_word(KIND_WEIGHT, 1, 1, 16'h0000, 1'b0));
    queue_word(make_word(KIND_WEIGHT, 63, 63, 16'h1234, 1'b1));
    queue_word(make_word(KIND_INPUT, 63, 63, 16'h8000, 1'b0));
    queue_word(make_word(KIND_INPUT, 0, 0, 16'h7fff, 1'b0));
    queue_word(make_word(KIND_INPUT, 1, 0, 16'h8000, 1'b1));
    set_layer(ACT_RELU, 2, 2, 16'h7fff);
    queue_word(make_word(KIND_INPUT, 1, 0, 16'h0800, 1'b1));
    set_layer(ACT_TANH, 2, 2, 16'h8000);
    queue_word(make_word(KIND_INPUT, 0, 0, 16'hf000, 1'b1));
    set_layer(ACT_SOFTMAX, 2, 2, 16'h0000);
    queue_word(make_word(KIND_INPUT, 1, 0, 16'h0000, 1'b1));
    set_layer(ACT_SIGMOID, 0, 0, 16'h0400);
    queue_word(make_word(KIND_INPUT, 0, 0, 16'h1000, 1'b1));
    set_layer(ACT_SOFTMAX, 127, 1, 16'h0000);
    for (int i = 0; i < 64; i++) queue_word(make_word(KIND_WEIGHT, i, 0, 16'h0100, 1'b0));
    for (int i = 1; i < 64; i++) queue_word(make_word(KIND_INPUT, i, 0, 16'h0200, 1'b0));
    queue_word(make_word(KIND_INPUT, 0, 0, 16'h0300, 1'b1));

    // random layers, with a few runs free of gaps on both sides
    phase = 0;
    while (words_queued < ITEM_TARGET) begin
      no_gaps = (phase % 6 == 3);
      random_layer();
      phase++;
    end
    wait_idle();
    $display("Ran %0d layers from %0d input words; checked %0d activations.",
             layers_run, words_taken, results_checked);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/dlf_pkg.sv
hdl/dlf_ram.sv
hdl/dlf_cell.sv
hdl/dlf_div.sv
hdl/dense_layer_forward_unit.sv
test/dense_layer_forward_unit_test.sv
